### hdl/ascii_ppm_decoder_defines.svh
// ----------------------------------------------------------------------------
// ascii_ppm_decoder_defines.svh
// Assertion macros shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef ASCII_PPM_DECODER_DEFINES_SVH
`define ASCII_PPM_DECODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another one on the following edge.
`define PPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ppm_dec_pkg.sv
// ----------------------------------------------------------------------------
// ppm_dec_pkg
// Types, codes and constants of the plain-text PPM decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppm_dec_pkg;

    localparam int unsigned VAL_W      = 25;
    localparam int unsigned MAG_W      = 24;
    localparam int unsigned DIM_OUT_W  = 13;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned NUM_W      = 32;

    localparam logic [VAL_W-1:0] VAL_LIMIT = 25'd16777215;
    localparam logic [VAL_W-1:0] VAL_OVER  = 25'd16777216;
    localparam logic [7:0]       SCALE_MUL = 8'd255;

    // Characters
    localparam logic [7:0] C_P     = 8'h50;
    localparam logic [7:0] C_3     = 8'h33;
    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_HT    = 8'h09;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_0     = 8'h30;
    localparam logic [7:0] C_9     = 8'h39;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_DONE, PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        RK_HEADER, RK_PIXEL, RK_DONE, RK_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        ERR_MAGIC, ERR_NUMBER, ERR_NONPOS, ERR_TRUNC, ERR_LARGE
    } t_err;

    typedef enum logic {
        OP_EMIT, OP_SCALE
    } t_op;

    typedef enum logic [1:0] {
        CH_RED, CH_GREEN, CH_BLUE
    } t_chan;

    typedef enum logic [1:0] {
        BS_IDLE, BS_DIV, BS_FIN, BS_OUT
    } t_bstate;

    // One job from the parser to the scaling back end
    typedef struct packed {
        t_op                  op;
        t_kind                kind;
        t_err                 err;
        logic [DIM_OUT_W-1:0] w;
        logic [DIM_OUT_W-1:0] h;
        logic [MAG_W-1:0]     val;
        logic                 neg;
        t_chan                chan;
        logic                 last;
    } t_job;

    function automatic t_job mk_job(
        input t_op                  op,
        input t_kind                kind,
        input t_err                 err,
        input logic [DIM_OUT_W-1:0] w,
        input logic [DIM_OUT_W-1:0] h,
        input logic [MAG_W-1:0]     val,
        input logic                 neg,
        input t_chan                chan
    );
        t_job j;
        j.op   = op;
        j.kind = kind;
        j.err  = err;
        j.w    = w;
        j.h    = h;
        j.val  = val;
        j.neg  = neg;
        j.chan = chan;
        j.last = 1'b0;
        return j;
    endfunction

endpackage

`default_nettype wire

### hdl/ppm_dec_if.sv
// ----------------------------------------------------------------------------
// ppm_dec_byte_if / ppm_dec_res_if
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ppm_dec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface ppm_dec_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [2:0]  error_code;
    logic        last_of_run;

    modport source (
        output valid, output result_kind, output red, output green, output blue,
        output image_width, output image_height, output error_code,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input result_kind, input red, input green, input blue,
        input image_width, input image_height, input error_code,
        input last_of_run, output ready
    );
endinterface

`default_nettype wire

### hdl/ppm_dec_fifo.sv
// ----------------------------------------------------------------------------
// ppm_dec_fifo
// Short job queue between the parser and the scaling back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_ppm_decoder_defines.svh"

module ppm_dec_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  ppm_dec_pkg::t_job      i_push_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output ppm_dec_pkg::t_job      o_pop_data,
    output logic                   o_empty
);
    import ppm_dec_pkg::*;

    localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    t_job             r_mem [FIFO_DEPTH];
    logic [IDX_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full     = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rd];

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + IDX_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + IDX_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    `PPM_ASSERT(a_no_overflow, !(i_push && o_full), "push into full queue")
    `PPM_ASSERT(a_no_underflow, !(i_pop && o_empty), "pop from empty queue")
    `PPM_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_cnt == $past(r_cnt) + CNT_W'(1), "count")

endmodule

`default_nettype wire

### hdl/ppm_dec_front.sv
// ----------------------------------------------------------------------------
// ppm_dec_front
// Tokenizer and header parser: turns bytes into jobs for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppm_dec_front #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    ppm_dec_byte_if.sink       i_byte,
    output logic               o_push,
    output ppm_dec_pkg::t_job  o_push_data,
    input  wire logic          i_full
);
    import ppm_dec_pkg::*;

    localparam int unsigned DW   = $clog2(MAX_DIM + 1);
    localparam int unsigned PL_W = 2 * DW;

    t_phase            r_phase, n_phase;
    logic              r_ic, n_ic, r_it, n_it;
    logic [1:0]        r_mp, n_mp;
    logic [VAL_W-1:0]  r_tv, n_tv;
    logic              r_tn, n_tn, r_ds, n_ds, r_dst, n_dst;
    logic [DW-1:0]     r_w, n_w, r_h, n_h;
    logic [PL_W-1:0]   r_pl, n_pl;
    t_chan             r_ch, n_ch;
    logic              r_pend;
    t_job              r_pend_job;

    t_job              ent0, ent1, jb;
    logic [1:0]        n_res;
    logic              accept;
    logic [7:0]        b;
    logic              ws, is_dig, tk, first, fin;
    logic [28:0]       acc;

    assign b      = i_byte.data_byte;
    assign i_byte.ready = !r_pend && !i_full;
    assign accept = i_byte.valid && i_byte.ready;

    // Step the parser over one byte
    always_comb begin
        n_phase = r_phase; n_ic = r_ic; n_it = r_it; n_mp = r_mp;
        n_tv = r_tv; n_tn = r_tn; n_ds = r_ds; n_dst = r_dst;
        n_w = r_w; n_h = r_h; n_pl = r_pl; n_ch = r_ch;
        ent0 = '0; ent1 = '0; jb = '0; n_res = 2'd0;
        tk = 1'b0; first = 1'b0; fin = 1'b0;
        ws     = b inside {C_SPACE, [C_HT:C_CR]};
        is_dig = b inside {[C_0:C_9]};
        acc    = {4'b0, r_tv} * 29'd10 + 29'(b - C_0);

        // classify byte
        if (n_phase < PH_DONE) begin
            if (n_ic) begin
                if (b == C_LF) begin
                    n_ic = 1'b0;
                end
            end else if (n_it) begin
                if (ws) begin
                    fin = 1'b1;
                end else begin
                    tk = 1'b1;
                end
            end else if (!ws) begin
                if (b == C_HASH) begin
                    n_ic = 1'b1;
                end else begin
                    n_it = 1'b1; n_mp = 2'd0; n_tv = '0;
                    n_tn = 1'b0; n_ds = 1'b0; n_dst = 1'b0;
                    tk = 1'b1; first = 1'b1;
                    acc = 29'(b - C_0);
                end
            end
        end

        // take one token character
        if (tk) begin
            if (n_phase == PH_MAGIC) begin
                if (n_mp == 2'd0 && b == C_P) begin
                    n_mp = 2'd1;
                end else if (n_mp == 2'd1 && b == C_3) begin
                    n_mp = 2'd2;
                end else begin
                    n_mp = 2'd3;
                end
            end else if (first && (b == C_PLUS || b == C_MINUS)) begin
                n_tn = (b == C_MINUS);
            end else if (!n_dst) begin
                if (is_dig) begin
                    n_tv = (acc > 29'(VAL_LIMIT)) ? VAL_OVER : acc[VAL_W-1:0];
                    n_ds = 1'b1;
                end else begin
                    n_dst = 1'b1;
                end
            end
        end

        if (i_byte.end_of_file && n_phase < PH_DONE && n_it) begin
            fin = 1'b1;
        end

        // finish a token
        if (fin) begin
            n_it = 1'b0;
            if (n_phase == PH_MAGIC) begin
                if (n_mp == 2'd2) begin
                    n_phase = PH_WIDTH;
                end else begin
                    jb = mk_job(OP_EMIT, RK_ERROR, ERR_MAGIC, '0, '0, '0, 1'b0, CH_RED);
                    if (n_res == 2'd0) ent0 = jb; else ent1 = jb;
                    n_res = n_res + 2'd1;
                    n_phase = PH_ERROR;
                end
            end else if (!n_ds || n_tv > VAL_LIMIT
                         || (n_phase <= PH_MAXVAL && (n_tn || n_tv == '0))
                         || (n_phase <= PH_HEIGHT && n_tv > VAL_W'(MAX_DIM))) begin
                if (!n_ds) begin
                    jb = mk_job(OP_EMIT, RK_ERROR, ERR_NUMBER, '0, '0, '0, 1'b0, CH_RED);
                end else if (n_tv > VAL_LIMIT) begin
                    jb = mk_job(OP_EMIT, RK_ERROR, ERR_LARGE, '0, '0, '0, 1'b0, CH_RED);
                end else if (n_phase <= PH_MAXVAL && (n_tn || n_tv == '0)) begin
                    jb = mk_job(OP_EMIT, RK_ERROR, ERR_NONPOS, '0, '0, '0, 1'b0, CH_RED);
                end else begin
                    jb = mk_job(OP_EMIT, RK_ERROR, ERR_LARGE, '0, '0, '0, 1'b0, CH_RED);
                end
                if (n_res == 2'd0) ent0 = jb; else ent1 = jb;
                n_res = n_res + 2'd1;
                n_phase = PH_ERROR;
            end else if (n_phase == PH_WIDTH) begin
                n_w = DW'(n_tv);
                n_phase = PH_HEIGHT;
            end else if (n_phase == PH_HEIGHT) begin
                n_h = DW'(n_tv);
                n_phase = PH_MAXVAL;
            end else if (n_phase == PH_MAXVAL) begin
                jb = mk_job(OP_EMIT, RK_HEADER, ERR_MAGIC, DIM_OUT_W'(n_w),
                            DIM_OUT_W'(n_h), n_tv[MAG_W-1:0], 1'b0, CH_RED);
                if (n_res == 2'd0) ent0 = jb; else ent1 = jb;
                n_res = n_res + 2'd1;
                n_pl = PL_W'(n_w) * PL_W'(n_h);
                n_ch = CH_RED;
                n_phase = PH_PIXELS;
            end else begin
                jb = mk_job(OP_SCALE, RK_PIXEL, ERR_MAGIC, '0, '0, n_tv[MAG_W-1:0],
                            n_tn, n_ch);
                if (n_res == 2'd0) ent0 = jb; else ent1 = jb;
                n_res = n_res + 2'd1;
                case (n_ch)
                    CH_RED:   n_ch = CH_GREEN;
                    CH_GREEN: n_ch = CH_BLUE;
                    default: begin
                        n_ch = CH_RED;
                        if (n_pl != '0) begin
                            n_pl = n_pl - PL_W'(1);
                        end
                        if (n_pl == '0) begin
                            jb = mk_job(OP_EMIT, RK_DONE, ERR_MAGIC, '0, '0, '0, 1'b0, CH_RED);
                            if (n_res == 2'd0) ent0 = jb; else ent1 = jb;
                            n_res = n_res + 2'd1;
                            n_phase = PH_DONE;
                        end
                    end
                endcase
            end
        end

        // end of file: flag truncation, then start over
        if (i_byte.end_of_file) begin
            if (n_phase < PH_DONE) begin
                jb = mk_job(OP_EMIT, RK_ERROR, ERR_TRUNC, '0, '0, '0, 1'b0, CH_RED);
                if (n_res == 2'd0) ent0 = jb; else ent1 = jb;
                n_res = n_res + 2'd1;
            end
            n_phase = PH_MAGIC; n_ic = 1'b0; n_it = 1'b0; n_mp = 2'd0;
            n_tv = '0; n_tn = 1'b0; n_ds = 1'b0; n_dst = 1'b0;
            n_w = '0; n_h = '0; n_pl = '0; n_ch = CH_RED;
        end

        ent0.last = (n_res == 2'd1);
        ent1.last = 1'b1;
    end

    // Push the first job now; hold a second one in a pending register until the queue has room
    assign o_push      = r_pend ? !i_full : (accept && n_res != 2'd0);
    assign o_push_data = r_pend ? r_pend_job : ent0;

    always_ff @(posedge i_clk) begin
        if (accept && n_res == 2'd2) begin
            r_pend_job <= ent1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_ic <= 1'b0; r_it <= 1'b0; r_mp <= 2'd0;
            r_tv <= '0; r_tn <= 1'b0; r_ds <= 1'b0; r_dst <= 1'b0;
            r_w <= '0; r_h <= '0; r_pl <= '0; r_ch <= CH_RED;
            r_pend <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase; r_ic <= n_ic; r_it <= n_it; r_mp <= n_mp;
                r_tv <= n_tv; r_tn <= n_tn; r_ds <= n_ds; r_dst <= n_dst;
                r_w <= n_w; r_h <= n_h; r_pl <= n_pl; r_ch <= n_ch;
            end
            if (accept && n_res == 2'd2) begin
                r_pend <= 1'b1;
            end else if (r_pend && !i_full) begin
                r_pend <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/ppm_dec_back.sv
// ----------------------------------------------------------------------------
// ppm_dec_back
// Scales pixel channels by 255/maxval with a serial divider; drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_ppm_decoder_defines.svh"

module ppm_dec_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  ppm_dec_pkg::t_job  i_job,
    output logic               o_pop,
    ppm_dec_res_if.source      o_res
);
    import ppm_dec_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W);

    t_bstate           r_state, n_state;
    logic [NUM_W-1:0]  r_num;
    logic [MAG_W-1:0]  r_rem, r_maxv;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg, r_last;
    t_chan             r_chan;
    logic [7:0]        r_red, r_green;

    logic [1:0]             r_kind;
    logic [7:0]             r_o_red, r_o_green, r_o_blue;
    logic [DIM_OUT_W-1:0]   r_o_w, r_o_h;
    logic [2:0]             r_o_err;
    logic                   r_o_last;

    logic [MAG_W:0]    trial, diff;
    logic              ge;
    logic [7:0]        v8;

    // One restoring divide step
    assign trial = {r_rem, r_num[NUM_W-1]};
    assign diff  = trial - {1'b0, r_maxv};
    assign ge    = (trial >= {1'b0, r_maxv});
    assign v8    = r_neg ? (8'd0 - r_num[7:0]) : r_num[7:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_job.op == OP_SCALE) ? BS_DIV : BS_OUT;
                end
            end
            BS_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = BS_FIN;
                end
            end
            BS_FIN:  n_state = (r_chan == CH_BLUE) ? BS_OUT : BS_IDLE;
            BS_OUT: begin
                if (o_res.ready) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_pop              = (r_state == BS_IDLE) && !i_empty;
        o_res.valid        = (r_state == BS_OUT);
        o_res.result_kind  = r_kind;
        o_res.red          = r_o_red;
        o_res.green        = r_o_green;
        o_res.blue         = r_o_blue;
        o_res.image_width  = r_o_w;
        o_res.image_height = r_o_h;
        o_res.error_code   = r_o_err;
        o_res.last_of_run  = r_o_last;
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    r_neg  <= i_job.neg;
                    r_chan <= i_job.chan;
                    r_last <= i_job.last;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_num  <= NUM_W'(i_job.val) * NUM_W'(SCALE_MUL);
                    if (i_job.op == OP_EMIT) begin
                        r_kind    <= i_job.kind;
                        r_o_red   <= '0;
                        r_o_green <= '0;
                        r_o_blue  <= '0;
                        r_o_w     <= (i_job.kind == RK_HEADER) ? i_job.w : '0;
                        r_o_h     <= (i_job.kind == RK_HEADER) ? i_job.h : '0;
                        r_o_err   <= (i_job.kind == RK_ERROR) ? i_job.err : '0;
                        r_o_last  <= i_job.last;
                        if (i_job.kind == RK_HEADER) begin
                            r_maxv <= i_job.val;
                        end
                    end
                end
            end
            BS_DIV: begin
                r_rem <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                r_num <= {r_num[NUM_W-2:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            BS_FIN: begin
                case (r_chan)
                    CH_RED:   r_red <= v8;
                    CH_GREEN: r_green <= v8;
                    default: begin
                        r_kind    <= RK_PIXEL;
                        r_o_red   <= r_red;
                        r_o_green <= r_green;
                        r_o_blue  <= v8;
                        r_o_w     <= '0;
                        r_o_h     <= '0;
                        r_o_err   <= '0;
                        r_o_last  <= r_last;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PPM_ASSERT(a_pop_idle, !o_pop || r_state == BS_IDLE, "pop outside idle")
    `PPM_ASSERT_NEXT(a_div_len, r_state == BS_DIV && r_cnt == CNT_W'(NUM_W - 1),
                     r_state == BS_FIN, "divider length")
    `PPM_ASSERT_NEXT(a_hold_out, o_res.valid && !o_res.ready, o_res.valid, "result dropped")

endmodule

`default_nettype wire

### hdl/ascii_ppm_decoder.sv
// ----------------------------------------------------------------------------
// ascii_ppm_decoder
// Plain-text PPM (P3) stream decoder, top level.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte carries one byte of the file per item; end_of_file marks the last.
//   o_res delivers header, pixel, done and error results; last_of_run marks
//   the final result caused by one byte (at most two per byte).
//   The parser takes one byte per cycle while the queue has room and no job
//   is pending, and pushes jobs into a four-entry queue; a byte that yields
//   two results holds its second job and blocks input until that job is pushed.
//   Each pixel channel is scaled by a bit-serial divider: a load in the
//   idle state, 32 steps and a finish state. Header, done and error results
//   skip the divider. The back end takes a new job only in its idle state,
//   once it is through with the previous one.
//   A stalled receiver holds the result register; the queue then fills and
//   i_byte.ready drops. Synchronous reset returns to expecting the magic
//   token; an end-of-file byte does the same for the next file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ascii_ppm_decoder #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ppm_dec_byte_if.sink  i_byte,
    ppm_dec_res_if.source o_res
);
    import ppm_dec_pkg::*;

    logic push, full, pop, empty;
    t_job push_data, pop_data;

    // Parse bytes into jobs
    ppm_dec_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    // Decouple parser and scaler
    ppm_dec_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (empty)
    );

    // Scale and emit results
    ppm_dec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (pop_data),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
